### design/dcp_pkg.sv
package dcp_pkg;

    // Pipeline depths of the iterative units, one result bit per stage.
    localparam int SQ_STEPS  = 25;
    localparam int DV1_STEPS = 25;
    localparam int DV2_STEPS = 26;

    localparam logic [15:0] GAIN_RESET = 16'd26214;
    localparam logic signed [27:0] POS_MAX = 28'sd8388607;
    localparam logic signed [27:0] POS_MIN = -28'sd8388608;

    // Lane order for the four end corrections.
    localparam int L_AX = 0;
    localparam int L_AY = 1;
    localparam int L_BX = 2;
    localparam int L_BY = 3;

    typedef logic signed [23:0] pos_t;

    typedef struct packed {
        pos_t ax;
        pos_t ay;
        pos_t bx;
        pos_t by;
    } pos4_t;

    typedef struct packed {
        pos4_t       pos;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [22:0] rest;
    } in_t;

    typedef struct packed {
        in_t         it;
        logic [24:0] adx;
        logic [24:0] ady;
        logic        sdx;
        logic        sdy;
        logic [49:0] sx;
        logic [49:0] sy;
    } sqr_t;

    typedef struct packed {
        in_t         it;
        logic [24:0] adx;
        logic [24:0] ady;
        logic        sdx;
        logic        sdy;
        logic [49:0] n;
        logic [27:0] rem;
        logic [24:0] root;
    } sq_t;

    // Fields carried unchanged from the error stage to the output.
    typedef struct packed {
        pos4_t       pos;
        logic        negx;
        logic        negy;
        logic        skip;
        logic [16:0] msum;
    } cmn_t;

    typedef struct packed {
        cmn_t        c;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [24:0] len;
        logic [50:0] numx;
        logic [50:0] numy;
    } err_t;

    typedef struct packed {
        cmn_t        c;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [24:0] len;
        logic [50:0] numx;
        logic [50:0] numy;
        logic [25:0] remx;
        logic [25:0] remy;
        logic [24:0] qx;
        logic [24:0] qy;
    } dv1_t;

    typedef struct packed {
        cmn_t             c;
        logic [3:0][40:0] p;
    } mul_t;

    typedef struct packed {
        cmn_t             c;
        logic [3:0][42:0] num;
    } scl_t;

    typedef struct packed {
        cmn_t             c;
        logic [3:0][42:0] num;
        logic [3:0][17:0] rem;
        logic [3:0][25:0] quo;
    } dv2_t;

    typedef struct packed {
        pos4_t pos;
        logic  skip;
    } out_t;

    // One step of the digit-by-digit square root: returns {rem, root}.
    function automatic logic [52:0] sqrt_step(input logic [27:0] rem,
                                              input logic [24:0] root,
                                              input logic [1:0]  pair);
        logic [27:0] sh;
        logic [27:0] trial;
        sh    = {rem[25:0], pair};
        trial = {1'b0, root, 2'b01};
        if (sh >= trial)
        begin
            return {sh - trial, root[23:0], 1'b1};
        end
        return {sh, root[23:0], 1'b0};
    endfunction

    // One restoring division step by the distance: returns {rem, quotient}.
    function automatic logic [50:0] div1_step(input logic [25:0] rem,
                                              input logic [24:0] q,
                                              input logic        b,
                                              input logic [24:0] den);
        logic [25:0] sh;
        sh = {rem[24:0], b};
        if (sh >= {1'b0, den})
        begin
            return {sh - {1'b0, den}, q[23:0], 1'b1};
        end
        return {sh, q[23:0], 1'b0};
    endfunction

    // One restoring division step by the mass sum: returns {rem, quotient}.
    function automatic logic [43:0] div2_step(input logic [17:0] rem,
                                              input logic [25:0] q,
                                              input logic        b,
                                              input logic [16:0] den);
        logic [17:0] sh;
        sh = {rem[16:0], b};
        if (sh >= {1'b0, den})
        begin
            return {sh - {1'b0, den}, q[24:0], 1'b1};
        end
        return {sh, q[24:0], 1'b0};
    endfunction

    function automatic pos_t sat24(input logic signed [27:0] v);
        if (v > POS_MAX)
        begin
            return pos_t'(POS_MAX[23:0]);
        end
        if (v < POS_MIN)
        begin
            return pos_t'(POS_MIN[23:0]);
        end
        return v[23:0];
    endfunction

endpackage

### design/distance_constraint_projection_unit.sv
// Structure: an accepted item passes through 82 register stages to the output register.
// Throughput: one item per cycle; the square root and the two dividers are pipelined
// with one result bit per stage, and the whole pipeline advances while the output
// register is empty or being taken.
// Reset: rst_n clears all stage valid bits and sets the gain register to 26214 (0.8).
module distance_constraint_projection_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] a_x,
    input  logic signed [23:0] a_y,
    input  logic signed [23:0] b_x,
    input  logic signed [23:0] b_y,
    input  logic [15:0]        a_inv_mass,
    input  logic [15:0]        b_inv_mass,
    input  logic [22:0]        rest_length,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] new_a_x,
    output logic signed [23:0] new_a_y,
    output logic signed [23:0] new_b_x,
    output logic signed [23:0] new_b_y,
    output logic               skipped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        relax_gain
);
    import dcp_pkg::*;

    logic [15:0]              gain_reg;
    in_t                      st0_reg;
    logic                     st0_v_reg;
    sqr_t                     st1_reg, st1_next;
    logic                     st1_v_reg;
    sq_t                      sq_reg  [SQ_STEPS];
    sq_t                      sq_next [SQ_STEPS];
    logic [SQ_STEPS-1:0]      sq_v_reg;
    err_t                     e_reg, e_next;
    logic                     e_v_reg;
    dv1_t                     dv1_reg  [DV1_STEPS];
    dv1_t                     dv1_next [DV1_STEPS];
    logic [DV1_STEPS-1:0]     dv1_v_reg;
    mul_t                     m1_reg, m1_next;
    logic                     m1_v_reg;
    scl_t                     m2_reg, m2_next;
    logic                     m2_v_reg;
    dv2_t                     dv2_reg  [DV2_STEPS];
    dv2_t                     dv2_next [DV2_STEPS];
    logic [DV2_STEPS-1:0]     dv2_v_reg;
    out_t                     out_reg, out_next;
    logic                     out_v_reg;
    logic                     adv;

    // The whole pipeline moves together unless a finished item waits at the output.
    assign adv       = !out_v_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= relax_gain;
        end
    end

    // Differences, magnitudes and squares.
    always_comb
    begin
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        dx = {st0_reg.pos.bx[23], st0_reg.pos.bx} - {st0_reg.pos.ax[23], st0_reg.pos.ax};
        dy = {st0_reg.pos.by[23], st0_reg.pos.by} - {st0_reg.pos.ay[23], st0_reg.pos.ay};
        st1_next.it  = st0_reg;
        st1_next.sdx = dx[24];
        st1_next.sdy = dy[24];
        st1_next.adx = dx[24] ? 25'(-dx) : 25'(dx);
        st1_next.ady = dy[24] ? 25'(-dy) : 25'(dy);
        st1_next.sx  = 50'(st1_next.adx) * 50'(st1_next.adx);
        st1_next.sy  = 50'(st1_next.ady) * 50'(st1_next.ady);
    end

    // Square root, one root bit per stage.
    always_comb
    begin
        sq_t cur;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                cur.it   = st1_reg.it;
                cur.adx  = st1_reg.adx;
                cur.ady  = st1_reg.ady;
                cur.sdx  = st1_reg.sdx;
                cur.sdy  = st1_reg.sdy;
                cur.n    = st1_reg.sx + st1_reg.sy;
                cur.rem  = '0;
                cur.root = '0;
            end
            else
            begin
                cur = sq_reg[k-1];
            end
            {cur.rem, cur.root} = sqrt_step(cur.rem, cur.root, cur.n[49-2*k -: 2]);
            sq_next[k] = cur;
        end
    end

    // Length error, skip decision and rounded dividends for the projection.
    always_comb
    begin
        sq_t                s;
        logic signed [25:0] err;
        logic [24:0]        aerr;
        s    = sq_reg[SQ_STEPS-1];
        err  = {1'b0, s.root} - {3'b000, s.it.rest};
        aerr = err[25] ? 25'(-err) : 25'(err);
        e_next.c.pos  = s.it.pos;
        e_next.c.negx = s.sdx ^ err[25];
        e_next.c.negy = s.sdy ^ err[25];
        e_next.c.skip = (s.it.ma == '0 && s.it.mb == '0) || s.root == '0;
        e_next.c.msum = {1'b0, s.it.ma} + {1'b0, s.it.mb};
        e_next.ma     = s.it.ma;
        e_next.mb     = s.it.mb;
        e_next.len    = s.root;
        e_next.numx   = 51'(50'(s.adx) * 50'(aerr)) + 51'(s.root[24:1]);
        e_next.numy   = 51'(50'(s.ady) * 50'(aerr)) + 51'(s.root[24:1]);
    end

    // Division by the distance, both axes side by side.
    always_comb
    begin
        dv1_t cur;
        for (int k = 0; k < DV1_STEPS; k++)
        begin
            if (k == 0)
            begin
                cur.c    = e_reg.c;
                cur.ma   = e_reg.ma;
                cur.mb   = e_reg.mb;
                cur.len  = e_reg.len;
                cur.numx = e_reg.numx;
                cur.numy = e_reg.numy;
                cur.remx = e_reg.numx[50:25];
                cur.remy = e_reg.numy[50:25];
                cur.qx   = '0;
                cur.qy   = '0;
            end
            else
            begin
                cur = dv1_reg[k-1];
            end
            {cur.remx, cur.qx} = div1_step(cur.remx, cur.qx, cur.numx[24-k], cur.len);
            {cur.remy, cur.qy} = div1_step(cur.remy, cur.qy, cur.numy[24-k], cur.len);
            dv1_next[k] = cur;
        end
    end

    // Inverse-mass products.
    always_comb
    begin
        dv1_t d;
        d = dv1_reg[DV1_STEPS-1];
        m1_next.c       = d.c;
        m1_next.p[L_AX] = 41'(d.qx) * 41'(d.ma);
        m1_next.p[L_AY] = 41'(d.qy) * 41'(d.ma);
        m1_next.p[L_BX] = 41'(d.qx) * 41'(d.mb);
        m1_next.p[L_BY] = 41'(d.qy) * 41'(d.mb);
    end

    // Gain products with the rounding half added; the low 15 bits drop out of the quotient.
    always_comb
    begin
        logic [57:0] t;
        m2_next.c = m1_reg.c;
        for (int i = 0; i < 4; i++)
        begin
            t = 58'(57'(m1_reg.p[i]) * 57'(gain_reg)) + 58'({m1_reg.c.msum, 14'b0});
            m2_next.num[i] = t[57:15];
        end
    end

    // Division by the mass sum, four lanes side by side.
    always_comb
    begin
        dv2_t cur;
        for (int k = 0; k < DV2_STEPS; k++)
        begin
            if (k == 0)
            begin
                cur.c   = m2_reg.c;
                cur.num = m2_reg.num;
                for (int i = 0; i < 4; i++)
                begin
                    cur.rem[i] = {1'b0, m2_reg.num[i][42:26]};
                    cur.quo[i] = '0;
                end
            end
            else
            begin
                cur = dv2_reg[k-1];
            end
            for (int i = 0; i < 4; i++)
            begin
                {cur.rem[i], cur.quo[i]} =
                    div2_step(cur.rem[i], cur.quo[i], cur.num[i][25-k], cur.c.msum);
            end
            dv2_next[k] = cur;
        end
    end

    // Apply the signed corrections and saturate.
    always_comb
    begin
        dv2_t               d;
        logic signed [27:0] cx;
        logic signed [27:0] cy;
        logic signed [27:0] dxb;
        logic signed [27:0] dyb;
        d   = dv2_reg[DV2_STEPS-1];
        cx  = d.c.negx ? -28'(d.quo[L_AX]) : 28'(d.quo[L_AX]);
        cy  = d.c.negy ? -28'(d.quo[L_AY]) : 28'(d.quo[L_AY]);
        dxb = d.c.negx ? -28'(d.quo[L_BX]) : 28'(d.quo[L_BX]);
        dyb = d.c.negy ? -28'(d.quo[L_BY]) : 28'(d.quo[L_BY]);
        out_next.skip = d.c.skip;
        if (d.c.skip)
        begin
            out_next.pos = d.c.pos;
        end
        else
        begin
            out_next.pos.ax = sat24(28'(d.c.pos.ax) + cx);
            out_next.pos.ay = sat24(28'(d.c.pos.ay) + cy);
            out_next.pos.bx = sat24(28'(d.c.pos.bx) - dxb);
            out_next.pos.by = sat24(28'(d.c.pos.by) - dyb);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_v_reg <= 1'b0;
            st1_v_reg <= 1'b0;
            sq_v_reg  <= '0;
            e_v_reg   <= 1'b0;
            dv1_v_reg <= '0;
            m1_v_reg  <= 1'b0;
            m2_v_reg  <= 1'b0;
            dv2_v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            st0_v_reg <= in_valid;
            st1_v_reg <= st0_v_reg;
            sq_v_reg  <= {sq_v_reg[SQ_STEPS-2:0], st1_v_reg};
            e_v_reg   <= sq_v_reg[SQ_STEPS-1];
            dv1_v_reg <= {dv1_v_reg[DV1_STEPS-2:0], e_v_reg};
            m1_v_reg  <= dv1_v_reg[DV1_STEPS-1];
            m2_v_reg  <= m1_v_reg;
            dv2_v_reg <= {dv2_v_reg[DV2_STEPS-2:0], m2_v_reg};
            out_v_reg <= dv2_v_reg[DV2_STEPS-1];
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st0_reg.pos.ax <= a_x;
            st0_reg.pos.ay <= a_y;
            st0_reg.pos.bx <= b_x;
            st0_reg.pos.by <= b_y;
            st0_reg.ma     <= a_inv_mass;
            st0_reg.mb     <= b_inv_mass;
            st0_reg.rest   <= rest_length;
            st1_reg        <= st1_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            e_reg <= e_next;
            for (int k = 0; k < DV1_STEPS; k++)
            begin
                dv1_reg[k] <= dv1_next[k];
            end
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            for (int k = 0; k < DV2_STEPS; k++)
            begin
                dv2_reg[k] <= dv2_next[k];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign new_a_x   = out_reg.pos.ax;
    assign new_a_y   = out_reg.pos.ay;
    assign new_b_x   = out_reg.pos.bx;
    assign new_b_y   = out_reg.pos.by;
    assign skipped   = out_reg.skip;

`ifndef SYNTHESIS
    // Back pressure comes only from a waiting result.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting result");

    // An accepted item occupies the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> st0_v_reg)
        else $error("accepted item did not enter the pipeline");

    // The finished root never exceeds the square root of its radicand.
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg[SQ_STEPS-1] |->
            (50'(sq_reg[SQ_STEPS-1].root) * 50'(sq_reg[SQ_STEPS-1].root)
             <= sq_reg[SQ_STEPS-1].n))
        else $error("square root too large");

    // The distance quotient times the divisor stays within the dividend.
    a_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (dv1_v_reg[DV1_STEPS-1] && dv1_reg[DV1_STEPS-1].len != '0) |->
            (51'(dv1_reg[DV1_STEPS-1].qx) * 51'(dv1_reg[DV1_STEPS-1].len)
             <= dv1_reg[DV1_STEPS-1].numx))
        else $error("distance quotient too large");
`endif

endmodule

### tb/distance_constraint_projection_unit_test.sv
`timescale 1ns / 100ps

module distance_constraint_projection_unit_test;
    import dcp_pkg::*;

    localparam int LATENCY    = 82;
    localparam int STALL_LIMIT = 4000;

    // One rod and the projected ends that it should produce.
    typedef struct {
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic [15:0]        ma;
        logic [15:0]        mb;
        logic [22:0]        rest;
    } rod_t;

    typedef struct {
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic               skip;
    } ends_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] a_x;
    logic signed [23:0] a_y;
    logic signed [23:0] b_x;
    logic signed [23:0] b_y;
    logic [15:0]        a_inv_mass;
    logic [15:0]        b_inv_mass;
    logic [22:0]        rest_length;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] new_a_x;
    logic signed [23:0] new_a_y;
    logic signed [23:0] new_b_x;
    logic signed [23:0] new_b_y;
    logic               skipped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        relax_gain;

    logic [15:0] gain_now;
    ends_t       pending_ends[$];
    int          error_count;
    int          idle_cycles;
    bit          calm;

    distance_constraint_projection_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .a_x         (a_x),
        .a_y         (a_y),
        .b_x         (b_x),
        .b_y         (b_y),
        .a_inv_mass  (a_inv_mass),
        .b_inv_mass  (b_inv_mass),
        .rest_length (rest_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_a_x     (new_a_x),
        .new_a_y     (new_a_y),
        .new_b_x     (new_b_x),
        .new_b_y     (new_b_y),
        .skipped     (skipped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .relax_gain  (relax_gain)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Integer square root, rounded down.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r  = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned near_div(input longint unsigned num,
                                                 input longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > 8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -8388608)
        begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Share of the along-rod correction for one end, gain applied.
    function automatic longint end_share(input longint q, input longint unsigned m,
                                         input longint unsigned msum);
        longint unsigned c;
        c = near_div(abs64(q) * m * gain_now, msum << 15);
        return q < 0 ? -longint'(c) : longint'(c);
    endfunction

    function automatic ends_t project_rod(input rod_t r);
        ends_t           e;
        longint          dx;
        longint          dy;
        longint          err;
        longint unsigned rod_len;
        longint unsigned msum;
        longint          qx;
        longint          qy;
        e.ax    = r.ax;
        e.ay    = r.ay;
        e.bx    = r.bx;
        e.by    = r.by;
        e.skip  = 1'b0;
        dx      = longint'(r.bx) - longint'(r.ax);
        dy      = longint'(r.by) - longint'(r.ay);
        rod_len = floor_root(abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy));
        if ((r.ma == 0 && r.mb == 0) || rod_len == 0)
        begin
            e.skip = 1'b1;
            return e;
        end
        err  = longint'(rod_len) - longint'(r.rest);
        msum = r.ma + r.mb;
        qx   = near_div(abs64(dx) * abs64(err), rod_len);
        qy   = near_div(abs64(dy) * abs64(err), rod_len);
        if ((dx < 0) != (err < 0))
        begin
            qx = -qx;
        end
        if ((dy < 0) != (err < 0))
        begin
            qy = -qy;
        end
        e.ax = clamp24(longint'(r.ax) + end_share(qx, r.ma, msum));
        e.ay = clamp24(longint'(r.ay) + end_share(qy, r.ma, msum));
        e.bx = clamp24(longint'(r.bx) - end_share(qx, r.mb, msum));
        e.by = clamp24(longint'(r.by) - end_share(qy, r.mb, msum));
        return e;
    endfunction

    // Send one rod; the expectation is queued when the item is accepted.
    // Valid is dropped only while idling, so back to back items keep it high.
    task automatic send_rod(input rod_t r);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        a_x         <= r.ax;
        a_y         <= r.ay;
        b_x         <= r.bx;
        b_y         <= r.by;
        a_inv_mass  <= r.ma;
        b_inv_mass  <= r.mb;
        rest_length <= r.rest;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_ends = {pending_ends, project_rod(r)};
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_ends.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_gain(input logic [15:0] g);
        drain_pipe();
        cfg_valid  <= 1'b1;
        relax_gain <= g;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        gain_now = g;
    endtask

    function automatic rod_t make_rod(input longint ax, input longint ay,
                                      input longint bx, input longint by,
                                      input int ma, input int mb, input int rest);
        rod_t r;
        r.ax   = ax[23:0];
        r.ay   = ay[23:0];
        r.bx   = bx[23:0];
        r.by   = by[23:0];
        r.ma   = ma[15:0];
        r.mb   = mb[15:0];
        r.rest = rest[22:0];
        return r;
    endfunction

    // Random rod: mostly nearby ends with a rest length near their distance.
    function automatic rod_t random_rod();
        rod_t r;
        int   span;
        r.ax = 24'($urandom());
        r.ay = 24'($urandom());
        r.ma = 16'($urandom());
        r.mb = 16'($urandom());
        r.rest = 23'($urandom());
        case ($urandom_range(9))
            0:
            begin
                r.bx = 24'($urandom());
                r.by = 24'($urandom());
            end
            1:
            begin
                r.bx = r.ax;
                r.by = r.ay;
            end
            default:
            begin
                span = 1 << $urandom_range(16, 4);
                r.bx = 24'(r.ax + $signed(24'($urandom_range(2 * span))) - span);
                r.by = 24'(r.ay + $signed(24'($urandom_range(2 * span))) - span);
                r.rest = 23'($urandom_range(2 * span));
            end
        endcase
        case ($urandom_range(9))
            0: r.ma = 16'd0;
            1: r.mb = 16'd0;
            2:
            begin
                r.ma = 16'd0;
                r.mb = 16'd0;
            end
            3: r.ma = 16'd4096;
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_edge_rods();
        send_rod(make_rod(0, 0, 2560, 0, 4096, 4096, 1280));
        send_rod(make_rod(0, 0, 0, 2560, 4096, 4096, 5000));
        send_rod(make_rod(100, 100, 100, 100, 4096, 4096, 256));
        send_rod(make_rod(0, 0, 1000, 1000, 0, 0, 10));
        send_rod(make_rod(0, 0, 1000, -700, 0, 4096, 10));
        send_rod(make_rod(0, 0, -1000, 700, 4096, 0, 3000));
        send_rod(make_rod(-8388608, -8388608, 8388607, 8388607, 65535, 65535, 0));
        send_rod(make_rod(8388607, 8388607, -8388608, -8388608, 65535, 1, 8388607));
        send_rod(make_rod(8388607, -8388608, -8388608, 8388607, 1, 65535, 0));
        send_rod(make_rod(-8388608, 0, 8388607, 0, 65535, 65535, 8388607));
        send_rod(make_rod(0, 0, 1, 0, 1, 1, 0));
        send_rod(make_rod(0, 0, 3, 4, 65535, 0, 5));
        send_rod(make_rod(8388600, 0, 8388607, 0, 65535, 65535, 8388607));
        send_rod(make_rod(-5, -5, 5, 5, 7, 9, 1));
    endtask

    task automatic test_random_rods(input int count);
        repeat (count)
        begin
            send_rod(random_rod());
        end
    endtask

    task automatic test_gain_settings();
        write_gain(16'd0);
        test_edge_rods();
        test_random_rods(60);
        write_gain(16'd32768);
        test_edge_rods();
        test_random_rods(60);
        write_gain(16'hFFFF);
        test_random_rods(80);
        write_gain(16'd1);
        test_random_rods(40);
        write_gain(16'($urandom()));
        test_random_rods(60);
        write_gain(GAIN_RESET);
    endtask

    // Result side: random stalls, compare every field with the oldest expectation.
    always @(posedge clk)
    begin
        ends_t e;
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(99) >= 22);
            if (out_valid && out_ready)
            begin
                if (pending_ends.size() == 0)
                begin
                    $display("%0t: unexpected result ax=%0d ay=%0d bx=%0d by=%0d skip=%0b",
                             $time, new_a_x, new_a_y, new_b_x, new_b_y, skipped);
                    error_count++;
                end
                else
                begin
                    e = pending_ends.pop_front();
                    if (new_a_x !== e.ax || new_a_y !== e.ay || new_b_x !== e.bx
                        || new_b_y !== e.by || skipped !== e.skip)
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d %0d skip=%0b",
                                 $time, e.ax, e.ay, e.bx, e.by, e.skip);
                        $display("%0t:          actual   %0d %0d %0d %0d skip=%0b",
                                 $time, new_a_x, new_a_y, new_b_x, new_b_y, skipped);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[distance_constraint_projection_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        a_x         <= '0;
        a_y         <= '0;
        b_x         <= '0;
        b_y         <= '0;
        a_inv_mass  <= '0;
        b_inv_mass  <= '0;
        rest_length <= '0;
        out_ready   <= 1'b0;
        cfg_valid   <= 1'b0;
        relax_gain  <= '0;
        error_count = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        gain_now    = GAIN_RESET;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_rods();
        test_random_rods(200);
        // Let the whole pipeline empty before sending more.
        drain_pipe();
        calm = 1'b1;
        test_random_rods(200);
        calm = 1'b0;
        test_gain_settings();
        test_random_rods(250);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_ends.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && pending_ends.size() == 0)
        begin
            $display("[distance_constraint_projection_unit] OK");
        end
        else
        begin
            $display("[distance_constraint_projection_unit] ERROR");
        end
        $finish;
    end

endmodule
